// ----- rtl/tcbs_pkg.sv -----
// tcbs_pkg: shared types and constants of the text control byte sanitiser
// payload structs of both channels and the front-to-back release interface
// no dependencies
package tcbs_pkg;

  // default number of escape parameter bytes that may be held
  localparam int MAX_PARAM_BYTES_DEF = 16;

  // release counts and blank counts, wide enough for the whole parameter range
  localparam int CNT_W = 6;

  localparam logic [7:0] SPACE_BYTE = 8'h20;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       string_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       string_done;
  } out_item_t;

  // release command: play out count bytes, blanking the first blank of them
  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [CNT_W-1:0] blank;
    logic             done;
  } rel_cmd_t;

  // front to back: byte queue write and release command
  typedef struct packed {
    logic       push;
    logic [7:0] push_byte;
    logic       cmd_push;
    rel_cmd_t   cmd;
  } fb_t;

  // back to front: room in both queues
  typedef struct packed {
    logic data_room;
    logic cmd_room;
  } bf_t;

endpackage

// ----- rtl/tcbs_front.sv -----
// tcbs_front: accepts input bytes, tracks utf-8 and escape state, issues releases
// every accepted byte is queued; held bytes are released later by a command
// depends on tcbs_pkg
module tcbs_front #(
  parameter int MAX_PARAM_BYTES = tcbs_pkg::MAX_PARAM_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  tcbs_pkg::in_item_t in_item,
  output logic               in_stall,
  input  logic               cfg_wr_en,
  input  logic               cfg_wr_data,
  output tcbs_pkg::fb_t      fb,
  input  tcbs_pkg::bf_t      bf
);
  import tcbs_pkg::*;

  localparam int HELD_DEPTH = MAX_PARAM_BYTES + 2;
  localparam int HW         = $clog2(HELD_DEPTH + 1);

  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_UTF  = 2'd1;
  localparam logic [1:0] MODE_ESC  = 2'd2;
  localparam logic [1:0] MODE_CSI  = 2'd3;

  localparam logic [7:0] CH_ESC   = 8'h1B;
  localparam logic [7:0] CH_LBRK  = 8'h5B;
  localparam logic [7:0] CH_M     = 8'h6D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_DEL   = 8'h7F;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_COLON = 8'h3A;

  // continuation bytes due after a lead byte, zero if not a lead
  function automatic logic [2:0] lead_cont(input logic [7:0] b);
    logic [2:0] n;
    n = 3'd0;
    if ((b & 8'hE0) == 8'hC0)      n = 3'd1;
    else if ((b & 8'hF0) == 8'hE0) n = 3'd2;
    else if ((b & 8'hF8) == 8'hF0) n = 3'd3;
    else if ((b & 8'hFC) == 8'hF8) n = 3'd4;
    else if ((b & 8'hFE) == 8'hFC) n = 3'd5;
    return n;
  endfunction

  logic [1:0]    mode_r, mode_nxt;
  logic [2:0]    cont_r, cont_nxt;
  logic [HW-1:0] held_r, held_nxt;
  logic          allow_r;

  logic [7:0]       b;
  logic             fin;
  logic             accept;
  logic [CNT_W-1:0] held_ext;

  // fresh-byte classification
  logic [2:0] fr_need;
  logic       fr_hold;
  logic [1:0] fr_mode;
  logic [7:0] fr_val;

  logic             do_fresh;
  logic [CNT_W-1:0] base;
  logic [CNT_W-1:0] blank;
  logic [CNT_W-1:0] cnt;
  logic             cmd_v;
  logic [7:0]       push_byte;
  logic [2:0]       cont_dec;
  logic             is_cont;
  logic             is_param;

  assign b        = in_item.in_byte;
  assign fin      = in_item.string_end;
  assign in_stall = !(bf.data_room && bf.cmd_room);
  assign accept   = in_valid && !in_stall;
  assign held_ext = CNT_W'(held_r);
  assign is_cont  = (b & 8'hC0) == 8'h80;
  assign is_param = (b >= CH_ZERO && b <= CH_NINE) || b == CH_SEMI || b == CH_COLON;
  assign cont_dec = cont_r - {2'b00, (cont_r != 3'd0)};

  // classify a byte seen with nothing pending
  always_comb begin
    fr_need = lead_cont(b);
    fr_hold = 1'b0;
    fr_mode = MODE_IDLE;
    fr_val  = b;
    if (fr_need != 3'd0) begin
      if (fin) begin
        fr_val = SPACE_BYTE;
      end else begin
        fr_hold = 1'b1;
        fr_mode = MODE_UTF;
      end
    end else if (b == CH_ESC) begin
      if (allow_r && !fin) begin
        fr_hold = 1'b1;
        fr_mode = MODE_ESC;
      end else begin
        fr_val = SPACE_BYTE;
      end
    end else if (b < 8'h20 || b == CH_DEL || b >= 8'h80) begin
      fr_val = (b == CH_LF || b == CH_CR) ? b : SPACE_BYTE;
    end
  end

  // scan state update and release command
  always_comb begin
    mode_nxt  = mode_r;
    cont_nxt  = cont_r;
    held_nxt  = held_r;
    do_fresh  = 1'b0;
    base      = '0;
    blank     = '0;
    cnt       = '0;
    cmd_v     = 1'b0;
    push_byte = b;
    case (mode_r)
      MODE_UTF: begin
        if (is_cont) begin
          if (cont_dec == 3'd0) begin
            cmd_v    = 1'b1;
            cnt      = held_ext + 1'b1;
            mode_nxt = MODE_IDLE;
            held_nxt = '0;
            cont_nxt = 3'd0;
          end else if (fin) begin
            cmd_v    = 1'b1;
            cnt      = held_ext + 1'b1;
            blank    = held_ext + 1'b1;
            mode_nxt = MODE_IDLE;
            held_nxt = '0;
            cont_nxt = 3'd0;
          end else begin
            held_nxt = held_r + 1'b1;
            cont_nxt = cont_dec;
          end
        end else begin
          base     = held_ext;
          blank    = held_ext;
          do_fresh = 1'b1;
        end
      end
      MODE_ESC: begin
        if (b == CH_LBRK) begin
          if (fin) begin
            cmd_v    = 1'b1;
            cnt      = held_ext + 1'b1;
            mode_nxt = MODE_IDLE;
            held_nxt = '0;
          end else begin
            held_nxt = held_r + 1'b1;
            mode_nxt = MODE_CSI;
          end
        end else begin
          base     = held_ext;
          blank    = held_ext;
          do_fresh = 1'b1;
        end
      end
      MODE_CSI: begin
        if (is_param && held_r < HW'(HELD_DEPTH)) begin
          if (fin) begin
            cmd_v    = 1'b1;
            cnt      = held_ext + 1'b1;
            mode_nxt = MODE_IDLE;
            held_nxt = '0;
          end else begin
            held_nxt = held_r + 1'b1;
          end
        end else if (!is_param && b == CH_M) begin
          cmd_v    = 1'b1;
          cnt      = held_ext + 1'b1;
          mode_nxt = MODE_IDLE;
          held_nxt = '0;
        end else begin
          // rejected escape: only the esc itself is blanked
          base     = held_ext;
          blank    = {{(CNT_W-1){1'b0}}, 1'b1};
          do_fresh = 1'b1;
        end
      end
      default: begin
        do_fresh = 1'b1;
      end
    endcase

    // pending bytes flushed, then the breaking byte starts afresh
    if (do_fresh) begin
      if (fr_hold) begin
        held_nxt = {{(HW-1){1'b0}}, 1'b1};
        mode_nxt = fr_mode;
        cont_nxt = fr_need;
        cmd_v    = base != '0;
        cnt      = base;
      end else begin
        push_byte = fr_val;
        held_nxt  = '0;
        mode_nxt  = MODE_IDLE;
        cont_nxt  = 3'd0;
        cmd_v     = 1'b1;
        cnt       = base + 1'b1;
      end
    end
  end

  // queue writes
  always_comb begin
    fb.push       = accept;
    fb.push_byte  = push_byte;
    fb.cmd_push   = accept && cmd_v;
    fb.cmd.count  = cnt;
    fb.cmd.blank  = blank;
    fb.cmd.done   = fin;
  end

  // scan state and colour enable
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      cont_r  <= 3'd0;
      held_r  <= '0;
      allow_r <= 1'b1;
    end else begin
      if (accept) begin
        mode_r <= mode_nxt;
        cont_r <= cont_nxt;
        held_r <= held_nxt;
      end
      if (cfg_wr_en) begin
        allow_r <= cfg_wr_data;
      end
    end
  end

endmodule

// ----- rtl/tcbs_back.sv -----
// tcbs_back: byte queue memory, release command queue and output playout
// plays out released bytes one per cycle while the output is not stalled, blanking as each command says
// depends on tcbs_pkg
module tcbs_back #(
  parameter int MAX_PARAM_BYTES = tcbs_pkg::MAX_PARAM_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  tcbs_pkg::fb_t       fb,
  output tcbs_pkg::bf_t       bf,
  output logic                out_valid,
  output tcbs_pkg::out_item_t out_item,
  input  logic                out_stall
);
  import tcbs_pkg::*;

  localparam int HELD_DEPTH = MAX_PARAM_BYTES + 2;
  localparam int DEPTH      = 2 ** $clog2(HELD_DEPTH + 4);
  localparam int AW         = $clog2(DEPTH);
  localparam logic [AW:0] DEPTH_C = (AW + 1)'(DEPTH);

  localparam int CQ_DEPTH = 4;
  localparam int CQW      = $clog2(CQ_DEPTH);
  localparam logic [CQW:0] CQ_DEPTH_C = (CQW + 1)'(CQ_DEPTH);

  // byte queue
  logic [7:0]  mem [DEPTH];
  logic [AW:0] wr_ptr_r, rd_ptr_r;
  logic [AW:0] fill;

  // command queue
  rel_cmd_t       cq [CQ_DEPTH];
  logic [CQW-1:0] cq_wr_r, cq_rd_r;
  logic [CQW:0]   cq_cnt_r, cq_cnt_nxt;
  rel_cmd_t       head;
  logic           cq_pop;

  // playout
  logic [CNT_W-1:0] pos_r;
  logic             issue;
  logic             pos_last;
  logic             out_can;
  logic             fetch_v_r;
  logic [7:0]       rd_data_r;
  logic             f_blank_r, f_last_r, f_done_r;
  logic             out_valid_r;
  out_item_t        out_r;

  assign fill         = wr_ptr_r - rd_ptr_r;
  assign bf.data_room = fill != DEPTH_C;
  assign bf.cmd_room  = cq_cnt_r != CQ_DEPTH_C;
  assign head         = cq[cq_rd_r];
  assign out_can      = !out_valid_r || !out_stall;
  assign issue        = (cq_cnt_r != '0) && (!fetch_v_r || out_can);
  assign pos_last     = pos_r == head.count - 1'b1;
  assign cq_pop       = issue && pos_last;
  assign out_valid    = out_valid_r;
  assign out_item     = out_r;

  // byte memory: write at the tail, registered read at the head
  always_ff @(posedge clk) begin
    if (fb.push) begin
      mem[wr_ptr_r[AW-1:0]] <= fb.push_byte;
    end
    if (issue) begin
      rd_data_r <= mem[rd_ptr_r[AW-1:0]];
      f_blank_r <= pos_r < head.blank;
      f_last_r  <= pos_last;
      f_done_r  <= pos_last && head.done;
    end
  end

  // command storage
  always_ff @(posedge clk) begin
    if (fb.cmd_push) begin
      cq[cq_wr_r] <= fb.cmd;
    end
  end

  always_comb begin
    cq_cnt_nxt = cq_cnt_r;
    if (fb.cmd_push && !cq_pop) begin
      cq_cnt_nxt = cq_cnt_r + 1'b1;
    end else if (!fb.cmd_push && cq_pop) begin
      cq_cnt_nxt = cq_cnt_r - 1'b1;
    end
  end

  // queue pointers and playout position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cq_wr_r  <= '0;
      cq_rd_r  <= '0;
      cq_cnt_r <= '0;
      pos_r    <= '0;
    end else begin
      cq_cnt_r <= cq_cnt_nxt;
      if (fb.push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (fb.cmd_push) begin
        cq_wr_r <= cq_wr_r + 1'b1;
      end
      if (issue) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
        pos_r    <= pos_last ? '0 : pos_r + 1'b1;
      end
      if (cq_pop) begin
        cq_rd_r <= cq_rd_r + 1'b1;
      end
    end
  end

  // fetch stage and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fetch_v_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (issue) begin
        fetch_v_r <= 1'b1;
      end else if (out_can) begin
        fetch_v_r <= 1'b0;
      end
      if (out_can) begin
        out_valid_r <= fetch_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_can && fetch_v_r) begin
      out_r.out_byte    <= f_blank_r ? SPACE_BYTE : rd_data_r;
      out_r.run_last    <= f_last_r;
      out_r.string_done <= f_done_r;
    end
  end

endmodule

// ----- rtl/text_control_byte_sanitizer.sv -----
// text_control_byte_sanitizer: one output byte per input byte, unsafe bytes blanked
// path: a byte released by a transfer passes the queues, the fetch register and the output register;
// bytes of an open utf-8 or escape sequence wait until the sequence is judged
// throughput: one byte per cycle in and out while neither side stalls, set by the single byte queue read port
// reset: synchronous active-low rst_n empties both queues, colour codes allowed
// depends on tcbs_pkg, tcbs_front, tcbs_back
module text_control_byte_sanitizer #(
  parameter int MAX_PARAM_BYTES = tcbs_pkg::MAX_PARAM_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  tcbs_pkg::in_item_t  in_item,
  output logic                in_stall,
  output logic                out_valid,
  output tcbs_pkg::out_item_t out_item,
  input  logic                out_stall,
  input  logic                cfg_wr_en,
  input  logic                cfg_wr_data
);
  import tcbs_pkg::*;

  fb_t fb;
  bf_t bf;

  // classification and hold tracking
  tcbs_front #(
    .MAX_PARAM_BYTES(MAX_PARAM_BYTES)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_item    (in_item),
    .in_stall   (in_stall),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .fb         (fb),
    .bf         (bf)
  );

  // queues and output playout
  tcbs_back #(
    .MAX_PARAM_BYTES(MAX_PARAM_BYTES)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .fb       (fb),
    .bf       (bf),
    .out_valid(out_valid),
    .out_item (out_item),
    .out_stall(out_stall)
  );

endmodule

// ----- sim/tcbs_checker.sv -----
// tcbs_checker: predicts the sanitised byte stream from observed input transfers
// and compares every output transfer field by field against the oldest prediction
// depends on tcbs_pkg
module tcbs_checker #(
  parameter int MAX_PARAM_BYTES = tcbs_pkg::MAX_PARAM_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  tcbs_pkg::in_item_t  in_item,
  input  logic                in_stall,
  input  logic                out_valid,
  input  tcbs_pkg::out_item_t out_item,
  input  logic                out_stall,
  input  logic                cfg_wr_en,
  input  logic                cfg_wr_data,
  output int                  fault_count,
  output int                  owed_count,
  output int                  checked_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import tcbs_pkg::*;

  localparam int HELD_DEPTH = MAX_PARAM_BYTES + 2;

  localparam logic [7:0] ESC_CHAR = 8'h1B;
  localparam logic [7:0] CSI_OPEN = 8'h5B;  // '['
  localparam logic [7:0] SGR_END  = 8'h6D;  // 'm'
  localparam logic [7:0] LF_CHAR  = 8'h0A;
  localparam logic [7:0] CR_CHAR  = 8'h0D;
  localparam logic [7:0] DEL_CHAR = 8'h7F;
  localparam logic [7:0] SEMI     = 8'h3B;
  localparam logic [7:0] COLON    = 8'h3A;

  typedef enum logic [1:0] {
    SCAN_IDLE,
    SCAN_UTF,
    SCAN_ESC,
    SCAN_CSI
  } scan_t;

  // predictor state
  logic        colours_on;
  scan_t       scan;
  int unsigned cont_due;
  int          held_n;
  logic [7:0]  held [HELD_DEPTH];
  out_item_t   clean_bytes_q[$];

  function automatic void emit(input logic [7:0] b);
    clean_bytes_q.push_back('{out_byte: b, run_last: 1'b0, string_done: 1'b0});
  endfunction

  function automatic void hold_byte(input logic [7:0] b);
    if (held_n < HELD_DEPTH) begin
      held[held_n] = b;
      held_n++;
    end
  endfunction

  function automatic void release_held(input bit blank_all, input bit blank_first);
    for (int i = 0; i < held_n; i++) begin
      emit((blank_all || (blank_first && i == 0)) ? SPACE_BYTE : held[i]);
    end
    held_n   = 0;
    cont_due = 0;
    scan     = SCAN_IDLE;
  endfunction

  // continuation bytes announced by a utf-8 lead byte, zero when not a lead
  function automatic int unsigned continuations(input logic [7:0] b);
    if (b[7:5] == 3'b110) return 1;
    if (b[7:4] == 4'b1110) return 2;
    if (b[7:3] == 5'b11110) return 3;
    if (b[7:2] == 6'b111110) return 4;
    if (b[7:1] == 7'b1111110) return 5;
    return 0;
  endfunction

  // judge a byte with nothing pending
  function automatic void start_fresh(input logic [7:0] b, input logic fin);
    int unsigned need;
    need     = continuations(b);
    scan     = SCAN_IDLE;
    held_n   = 0;
    cont_due = 0;
    if (need > 0) begin
      if (fin) begin
        emit(SPACE_BYTE);
      end else begin
        hold_byte(b);
        cont_due = need;
        scan     = SCAN_UTF;
      end
    end else if (b == ESC_CHAR) begin
      if (colours_on && !fin) begin
        hold_byte(b);
        scan = SCAN_ESC;
      end else begin
        emit(SPACE_BYTE);
      end
    end else if (b < 8'h20 || b == DEL_CHAR || b >= 8'h80) begin
      emit((b == LF_CHAR || b == CR_CHAR) ? b : SPACE_BYTE);
    end else begin
      emit(b);
    end
  endfunction

  // one input transfer: append every byte it releases to the expected stream
  function automatic void sanitise_byte(input logic [7:0] b, input logic fin);
    int        before_n;
    bit        is_param;
    out_item_t tail;
    before_n = clean_bytes_q.size();
    is_param = (b >= 8'h30 && b <= 8'h39) || b == SEMI || b == COLON;
    case (scan)
      SCAN_UTF: begin
        if (b[7:6] == 2'b10) begin
          hold_byte(b);
          if (cont_due > 0) cont_due--;
          if (cont_due == 0) release_held(1'b0, 1'b0);
          else if (fin) release_held(1'b1, 1'b0);
        end else begin
          release_held(1'b1, 1'b0);
          start_fresh(b, fin);
        end
      end
      SCAN_ESC: begin
        if (b == CSI_OPEN) begin
          hold_byte(b);
          scan = SCAN_CSI;
          if (fin) release_held(1'b0, 1'b0);
        end else begin
          release_held(1'b1, 1'b0);
          start_fresh(b, fin);
        end
      end
      SCAN_CSI: begin
        if (is_param) begin
          if (held_n < HELD_DEPTH) begin
            hold_byte(b);
            if (fin) release_held(1'b0, 1'b0);
          end else begin
            // too many parameters: escape rejected, byte judged afresh
            release_held(1'b0, 1'b1);
            start_fresh(b, fin);
          end
        end else if (b == SGR_END) begin
          release_held(1'b0, 1'b0);
          emit(b);
        end else begin
          release_held(1'b0, 1'b1);
          start_fresh(b, fin);
        end
      end
      default: start_fresh(b, fin);
    endcase
    // flag the last byte released by this transfer
    if (clean_bytes_q.size() > before_n) begin
      tail             = clean_bytes_q.pop_back();
      tail.run_last    = 1'b1;
      tail.string_done = fin;
      clean_bytes_q.push_back(tail);
    end
  endfunction

  // sample both channels and the register port at the rising edge
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      colours_on    = 1'b1;
      scan          = SCAN_IDLE;
      cont_due      = 0;
      held_n        = 0;
      fault_count   = 0;
      checked_count = 0;
      clean_bytes_q.delete();
    end else begin
      if (cfg_wr_en) colours_on = cfg_wr_data;
      if (in_valid && !in_stall) sanitise_byte(in_item.in_byte, in_item.string_end);
      if (out_valid && !out_stall) begin
        if (clean_bytes_q.size() == 0) begin
          $error("unexpected transfer: out_byte %0h with nothing expected", out_item.out_byte);
          fault_count++;
        end else begin
          want = clean_bytes_q.pop_front();
          checked_count++;
          if (out_item.out_byte !== want.out_byte) begin
            $error("out_byte: expected %0h, got %0h", want.out_byte, out_item.out_byte);
            fault_count++;
          end
          if (out_item.run_last !== want.run_last) begin
            $error("run_last: expected %0b, got %0b", want.run_last, out_item.run_last);
            fault_count++;
          end
          if (out_item.string_done !== want.string_done) begin
            $error("string_done: expected %0b, got %0b", want.string_done,
                   out_item.string_done);
            fault_count++;
          end
        end
      end
    end
    owed_count = clean_bytes_q.size();
  end

endmodule

// ----- sim/tb_top.sv -----
// tb_top: drives byte strings and colour register writes into the sanitiser
// with random idling and a long output hold-off, and reports the verdict
// depends on tcbs_pkg, text_control_byte_sanitizer, tcbs_checker
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import tcbs_pkg::*;

  localparam int CYCLE_LIMIT  = 60000;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES  = 80;
  localparam int PHASES       = 6;
  localparam int PHASE_BYTES  = 21;

  localparam logic [7:0] ESC_CHAR = 8'h1B;
  localparam logic [7:0] CSI_OPEN = 8'h5B;
  localparam logic [7:0] SGR_END  = 8'h6D;
  localparam logic [7:0] SEMI     = 8'h3B;
  localparam logic [7:0] COLON    = 8'h3A;

  logic      clk;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  in_item_t  in_item = '0;
  logic      in_stall;
  logic      out_valid;
  out_item_t out_item;
  logic      out_stall = 1'b0;
  logic      cfg_wr_en = 1'b0;
  logic      cfg_wr_data = 1'b0;

  int fault_count;
  int owed_count;
  int checked_count;

  bit         calm = 1'b0;     // no idling on either side
  bit         squeeze = 1'b0;  // request a long output hold-off
  int         sent = 0;
  int         strings = 0;
  int         cfg_writes = 0;
  logic [7:0] text_q[$];

  text_control_byte_sanitizer i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_item    (in_item),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_item   (out_item),
    .out_stall  (out_stall),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  tcbs_checker i_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_item      (in_item),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_item     (out_item),
    .out_stall    (out_stall),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .fault_count  (fault_count),
    .owed_count   (owed_count),
    .checked_count(checked_count)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // run limit
  initial begin
    int unsigned cycles;
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // output side: random stalls, or one long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (squeeze) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        squeeze = 1'b0;
        out_stall <= 1'b0;
      end else begin
        out_stall <= !calm && ($urandom_range(99) < 14);
      end
    end
  end

  // offer one byte, return at the falling edge after its transfer
  task automatic put_byte(input logic [7:0] b, input logic fin);
    while (!calm && $urandom_range(99) < 14) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= '{in_byte: b, string_end: fin};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    sent++;
  endtask

  task automatic send_text();
    for (int i = 0; i < text_q.size(); i++) put_byte(text_q[i], i == text_q.size() - 1);
    strings++;
  endtask

  // stop offering and let every pending byte drain out
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (owed_count != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_colour(input logic allow);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= allow;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    cfg_writes++;
  endtask

  function automatic logic [7:0] param_char();
    int unsigned r;
    r = $urandom_range(11);
    if (r < 10) return 8'(8'h30 + r);
    return (r == 10) ? SEMI : COLON;
  endfunction

  // one piece of text: plain, utf-8, colour escape, control or noise
  function automatic void add_fragment();
    int unsigned kind;
    int unsigned len;
    int unsigned keep;
    int unsigned np;
    int unsigned lead;
    kind = $urandom_range(9);
    case (kind)
      0, 1: begin
        repeat ($urandom_range(1, 4)) text_q.push_back(8'($urandom_range(8'h20, 8'h7E)));
      end
      2, 3: begin
        len  = $urandom_range(2, 6);
        lead = ((32'hFF << (8 - len)) & 32'hFF) | ($urandom & ((1 << (7 - len)) - 1));
        text_q.push_back(8'(lead));
        // now and then cut the sequence short
        keep = ($urandom_range(4) == 0) ? $urandom_range(0, len - 2) : len - 1;
        repeat (keep) text_q.push_back({2'b10, 6'($urandom)});
      end
      4, 5, 6: begin
        text_q.push_back(ESC_CHAR);
        text_q.push_back(CSI_OPEN);
        np = ($urandom_range(9) == 0) ? $urandom_range(15, 18) : $urandom_range(0, 6);
        repeat (np) text_q.push_back(param_char());
        case ($urandom_range(5))
          4: ;
          5: text_q.push_back(8'($urandom));
          default: text_q.push_back(SGR_END);
        endcase
      end
      7: begin
        case ($urandom_range(3))
          0: text_q.push_back(8'h7F);
          1: text_q.push_back(ESC_CHAR);
          default: text_q.push_back(8'($urandom_range(0, 31)));
        endcase
      end
      default: text_q.push_back(8'($urandom));
    endcase
  endfunction

  function automatic void compose_text();
    text_q.delete();
    repeat ($urandom_range(1, 5)) add_fragment();
  endfunction

  // stimulus and verdict
  initial begin
    int target;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // controls, del, stray and invalid high bytes
    text_q = '{8'h00, 8'h7F, 8'h0A, 8'h0D, 8'h80, 8'hFE, 8'hFF};
    send_text();
    // complete two-byte sequence, then a broken three-byte one
    text_q = '{8'hC3, 8'hA9, 8'hE2, 8'h82, 8'h78};
    send_text();
    // string ends inside a sequence
    text_q = '{8'hE2, 8'h82};
    send_text();
    // lead byte as final byte
    text_q = '{8'hF0};
    send_text();
    // colour code, rejected escape, parameters cut by the end of string
    text_q = '{ESC_CHAR, CSI_OPEN, 8'h33, 8'h31, SGR_END, ESC_CHAR, 8'h58,
               ESC_CHAR, CSI_OPEN, 8'h37};
    send_text();
    // lone escape as final byte
    text_q = '{ESC_CHAR};
    send_text();

    // parameter run one past the limit
    text_q = '{ESC_CHAR, CSI_OPEN};
    repeat (MAX_PARAM_BYTES_DEF + 1) text_q.push_back(param_char());
    text_q.push_back(SGR_END);
    send_text();

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph > 0) begin
        wait_drained();
        write_colour(ph % 2 == 0);
      end
      calm = (ph == 2);
      if (ph == 3) squeeze = 1'b1;
      target = sent + PHASE_BYTES;
      while (sent < target) begin
        compose_text();
        // strings always end, so nothing is held across a register write
        send_text();
      end
    end

    wait_drained();
    $display("summary: %0d bytes in %0d strings, %0d results checked, %0d colour writes",
             sent, strings, checked_count, cfg_writes);
    if (fault_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- text_control_byte_sanitizer.f -----
rtl/tcbs_pkg.sv
rtl/tcbs_front.sv
rtl/tcbs_back.sv
rtl/text_control_byte_sanitizer.sv
sim/tcbs_checker.sv
sim/tb_top.sv
